// ===== hdl/mse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants of the MIPS subset execute unit: opcode and
// funct codes, the decoded operation set and the queue entry format.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned DMEM_WORDS_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Primary opcodes
  localparam logic [5:0] OPC_SPECIAL = 6'b000000;
  localparam logic [5:0] OPC_J       = 6'b000010;
  localparam logic [5:0] OPC_JAL     = 6'b000011;
  localparam logic [5:0] OPC_BEQ     = 6'b000100;
  localparam logic [5:0] OPC_BNE     = 6'b000101;
  localparam logic [5:0] OPC_ADDI    = 6'b001000;
  localparam logic [5:0] OPC_ADDIU   = 6'b001001;
  localparam logic [5:0] OPC_SLTI    = 6'b001010;
  localparam logic [5:0] OPC_SLTIU   = 6'b001011;
  localparam logic [5:0] OPC_ANDI    = 6'b001100;
  localparam logic [5:0] OPC_ORI     = 6'b001101;
  localparam logic [5:0] OPC_LUI     = 6'b001111;
  localparam logic [5:0] OPC_LW      = 6'b100011;
  localparam logic [5:0] OPC_SW      = 6'b101011;

  // Function codes of the register format
  localparam logic [5:0] FN_SLL     = 6'b000000;
  localparam logic [5:0] FN_SRL     = 6'b000010;
  localparam logic [5:0] FN_JR      = 6'b001000;
  localparam logic [5:0] FN_SYSCALL = 6'b001100;
  localparam logic [5:0] FN_ADD     = 6'b100000;
  localparam logic [5:0] FN_ADDU    = 6'b100001;
  localparam logic [5:0] FN_SUB     = 6'b100010;
  localparam logic [5:0] FN_SUBU    = 6'b100011;
  localparam logic [5:0] FN_AND     = 6'b100100;
  localparam logic [5:0] FN_OR      = 6'b100101;
  localparam logic [5:0] FN_NOR     = 6'b100111;
  localparam logic [5:0] FN_SLT     = 6'b101010;
  localparam logic [5:0] FN_SLTU    = 6'b101011;

  // Register numbers with a fixed role
  localparam logic [4:0] GPR_ZERO = 5'd0;
  localparam logic [4:0] GPR_V0   = 5'd2;
  localparam logic [4:0] GPR_A0   = 5'd4;
  localparam logic [4:0] GPR_RA   = 5'd31;

  // Syscall service codes taken from v0
  localparam logic [31:0] SYS_PRINT_INT = 32'd1;
  localparam logic [31:0] SYS_EXIT      = 32'd10;

  typedef enum logic [1:0] {
    FLT_NONE    = 2'd0,
    FLT_FUNCT   = 2'd1,
    FLT_OPCODE  = 2'd2,
    FLT_SYSCALL = 2'd3
  } fault_e_t;

  typedef enum logic [4:0] {
    OP_SLL, OP_SRL, OP_JR, OP_SYSCALL, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_NOR,
    OP_SLT, OP_SLTU, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_SLTI, OP_SLTIU,
    OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_SW, OP_BAD_FUNCT, OP_BAD_OPCODE
  } op_e_t;

  typedef struct packed {
    op_e_t       op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  wr_idx;
    logic [4:0]  shamt;
    logic [15:0] imm;
    logic [25:0] target;
  } uop_t;

endpackage

// ===== hdl/mse_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_in_if
// Instruction channel: one instruction word per item.
// ----------------------------------------------------------------------------
interface mse_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr;

  modport source (output valid, output instr, input ready);
  modport sink   (input valid, input instr, output ready);
endinterface

// ===== hdl/mse_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_out_if
// Result channel: one architectural result item per executed instruction.
// ----------------------------------------------------------------------------
interface mse_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        next_pc;
  logic               reg_write;
  logic [4:0]         reg_index;
  logic [31:0]        reg_value;
  logic               print_valid;
  logic signed [31:0] print_value;
  logic               halted;
  logic [1:0]         fault;

  modport source (output valid, output next_pc, output reg_write, output reg_index,
                  output reg_value, output print_valid, output print_value,
                  output halted, output fault, input ready);
  modport sink   (input valid, input next_pc, input reg_write, input reg_index,
                  input reg_value, input print_valid, input print_value,
                  input halted, input fault, output ready);
endinterface

// ===== hdl/mse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_front
// Accepts instruction items, decodes them into operations and pushes them
// into the issue queue.
// ----------------------------------------------------------------------------
module mse_front (
  mse_in_if.sink        req,
  input  logic          clearing,
  input  logic          q_full,
  output logic          push,
  output mse_pkg::uop_t push_uop
);
  import mse_pkg::*;

  logic [5:0] opc;
  logic [5:0] fn;

  assign opc       = req.instr[31:26];
  assign fn        = req.instr[5:0];
  assign req.ready = !clearing && !q_full;
  assign push      = req.valid && req.ready;

  always_comb begin
    push_uop        = '0;
    push_uop.rs     = req.instr[25:21];
    push_uop.rt     = req.instr[20:16];
    push_uop.shamt  = req.instr[10:6];
    push_uop.imm    = req.instr[15:0];
    push_uop.target = req.instr[25:0];
    push_uop.wr_idx = req.instr[20:16];
    push_uop.op     = OP_BAD_OPCODE;
    case (opc)
      OPC_SPECIAL: begin
        push_uop.wr_idx = req.instr[15:11];
        case (fn)
          FN_SLL:           push_uop.op = OP_SLL;
          FN_SRL:           push_uop.op = OP_SRL;
          FN_JR:            push_uop.op = OP_JR;
          FN_SYSCALL:       push_uop.op = OP_SYSCALL;
          FN_ADD, FN_ADDU:  push_uop.op = OP_ADD;
          FN_SUB, FN_SUBU:  push_uop.op = OP_SUB;
          FN_AND:           push_uop.op = OP_AND;
          FN_OR:            push_uop.op = OP_OR;
          FN_NOR:           push_uop.op = OP_NOR;
          FN_SLT:           push_uop.op = OP_SLT;
          FN_SLTU:          push_uop.op = OP_SLTU;
          default:          push_uop.op = OP_BAD_FUNCT;
        endcase
      end
      OPC_J:     push_uop.op = OP_J;
      OPC_JAL: begin
        push_uop.op     = OP_JAL;
        push_uop.wr_idx = GPR_RA;
      end
      OPC_BEQ:   push_uop.op = OP_BEQ;
      OPC_BNE:   push_uop.op = OP_BNE;
      OPC_ADDI, OPC_ADDIU: push_uop.op = OP_ADDI;
      OPC_SLTI:  push_uop.op = OP_SLTI;
      OPC_SLTIU: push_uop.op = OP_SLTIU;
      OPC_ANDI:  push_uop.op = OP_ANDI;
      OPC_ORI:   push_uop.op = OP_ORI;
      OPC_LUI:   push_uop.op = OP_LUI;
      OPC_LW:    push_uop.op = OP_LW;
      OPC_SW:    push_uop.op = OP_SW;
      default:   push_uop.op = OP_BAD_OPCODE;
    endcase
  end

endmodule

// ===== hdl/mse_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_queue
// Short issue queue of decoded operations between decode and execute.
// ----------------------------------------------------------------------------
module mse_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mse_pkg::uop_t push_uop,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output mse_pkg::uop_t head
);
  import mse_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  uop_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_uop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/mse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_back
// Execute stage: register file, program counter, data memory with its
// address reduction pipeline, and the registered result item.
// ----------------------------------------------------------------------------
module mse_back #(
  parameter int unsigned DMEM_WORDS = mse_pkg::DMEM_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_not_empty,
  input  mse_pkg::uop_t q_head,
  output logic          pop,
  output logic          clearing,
  mse_out_if.source     rsp
);
  import mse_pkg::*;

  localparam int unsigned AW = $clog2(DMEM_WORDS);
  localparam logic [29:0] DW30 = 30'(DMEM_WORDS);
  // floor(2^30 / depth): the estimated quotient is low by at most one.
  localparam logic [29:0] RECIP = 30'((64'd1 << 30) / DMEM_WORDS);

  typedef enum logic [2:0] {
    MEM_ADDR, MEM_RECIP, MEM_QUOT, MEM_IDX, MEM_ACCESS, MEM_DATA
  } mem_phase_e_t;

  // Architectural state
  logic [31:0] gpr [32];
  logic [31:0] gpr_vld;
  logic [31:0] dmem [DMEM_WORDS];
  logic [31:0] pc;
  logic        halt_flag;
  logic [31:0] v0_copy;
  logic [31:0] a0_copy;

  // Execute stage
  logic        x_valid;
  uop_t        xu;
  logic [31:0] va;
  logic [31:0] vb;
  mem_phase_e_t mph;

  // Address reduction pipeline
  logic [29:0]   w_reg;
  logic [59:0]   prod_reg;
  logic [29:0]   qd_reg;
  logic [AW-1:0] idx_reg;
  logic [31:0]   dmem_rdata;
  logic [59:0]   qd_full;
  logic [29:0]   rem;
  logic [29:0]   rem_sub;

  // Clearing sweep
  logic          clr_busy;
  logic [AW-1:0] clr_idx;

  // Result registers
  logic        o_valid;
  logic [31:0] o_next_pc;
  logic        o_reg_write;
  logic [4:0]  o_reg_index;
  logic [31:0] o_reg_value;
  logic        o_print_valid;
  logic [31:0] o_print_value;
  logic        o_halted;
  fault_e_t    o_fault;

  // Execute combinational results
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] seq;
  logic [31:0] jtarget;
  logic [31:0] btarget;
  logic [31:0] addr_sum;
  logic [31:0] wval;
  logic [31:0] npc;
  logic        wr;
  logic        prt;
  logic        set_halt;
  fault_e_t    flt;
  logic        is_mem;
  logic        mem_done;
  logic        out_free;
  logic        x_fire;
  logic        x_take;
  logic        gpr_we;

  assign clearing = clr_busy;
  assign simm     = {{16{xu.imm[15]}}, xu.imm};
  assign zimm     = {16'h0000, xu.imm};
  assign seq      = pc + 32'd4;
  assign jtarget  = {seq[31:28], xu.target, 2'b00};
  assign btarget  = seq + {simm[29:0], 2'b00};
  assign addr_sum = va + simm;

  assign is_mem   = (xu.op == OP_LW) || (xu.op == OP_SW);
  assign mem_done = ((xu.op == OP_SW) && (mph == MEM_ACCESS))
                 || ((xu.op == OP_LW) && (mph == MEM_DATA));
  assign out_free = !o_valid || rsp.ready;
  assign x_fire   = x_valid && out_free && (halt_flag || !is_mem || mem_done);
  assign x_take   = q_not_empty && (!x_valid || x_fire);
  assign pop      = x_take;

  always_comb begin
    wval     = '0;
    npc      = seq;
    wr       = 1'b1;
    prt      = 1'b0;
    set_halt = 1'b0;
    flt      = FLT_NONE;
    case (xu.op)
      OP_SLL:   wval = vb << xu.shamt;
      OP_SRL:   wval = vb >> xu.shamt;
      OP_JR: begin
        wr  = 1'b0;
        npc = va;
      end
      OP_SYSCALL: begin
        wr = 1'b0;
        if (v0_copy == SYS_PRINT_INT) begin
          prt = 1'b1;
        end else if (v0_copy == SYS_EXIT) begin
          set_halt = 1'b1;
        end else begin
          flt = FLT_SYSCALL;
        end
      end
      OP_ADD:   wval = va + vb;
      OP_SUB:   wval = va - vb;
      OP_AND:   wval = va & vb;
      OP_OR:    wval = va | vb;
      OP_NOR:   wval = ~(va | vb);
      OP_SLT:   wval = {31'd0, $signed(va) < $signed(vb)};
      OP_SLTU:  wval = {31'd0, va < vb};
      OP_J: begin
        wr  = 1'b0;
        npc = jtarget;
      end
      OP_JAL: begin
        wval = seq;
        npc  = jtarget;
      end
      OP_BEQ: begin
        wr = 1'b0;
        if (va == vb) npc = btarget;
      end
      OP_BNE: begin
        wr = 1'b0;
        if (va != vb) npc = btarget;
      end
      OP_ADDI:  wval = addr_sum;
      OP_SLTI:  wval = {31'd0, $signed(va) < $signed(simm)};
      OP_SLTIU: wval = {31'd0, va < simm};
      OP_ANDI:  wval = va & zimm;
      OP_ORI:   wval = va | zimm;
      OP_LUI:   wval = {xu.imm, 16'h0000};
      OP_LW:    wval = dmem_rdata;
      OP_SW:    wr = 1'b0;
      OP_BAD_FUNCT: begin
        wr  = 1'b0;
        flt = FLT_FUNCT;
      end
      default: begin
        wr  = 1'b0;
        flt = FLT_OPCODE;
      end
    endcase
  end

  assign gpr_we = x_fire && !halt_flag && (flt == FLT_NONE) && wr
               && (xu.wr_idx != GPR_ZERO);

  // Register file: one write port, two registered read ports. A write in the
  // same cycle is forwarded to the item entering execute.
  always_ff @(posedge clk) begin
    if (gpr_we) begin
      gpr[xu.wr_idx] <= wval;
    end
    if (x_take) begin
      if (gpr_we && (xu.wr_idx == q_head.rs)) begin
        va <= wval;
      end else begin
        va <= gpr_vld[q_head.rs] ? gpr[q_head.rs] : 32'd0;
      end
      if (gpr_we && (xu.wr_idx == q_head.rt)) begin
        vb <= wval;
      end else begin
        vb <= gpr_vld[q_head.rt] ? gpr[q_head.rt] : 32'd0;
      end
      xu <= q_head;
    end
  end

  // Word index = (address / 4) mod depth, by reciprocal multiply and one
  // correcting subtract. The chain runs freely behind the execute operands.
  assign qd_full = 60'(prod_reg[59:30]) * 60'(DW30);
  assign rem     = w_reg - qd_reg;
  assign rem_sub = rem - DW30;

  always_ff @(posedge clk) begin
    w_reg    <= addr_sum[31:2];
    prod_reg <= 60'(w_reg) * 60'(RECIP);
    qd_reg   <= qd_full[29:0];
    idx_reg  <= (rem < DW30) ? rem[AW-1:0] : rem_sub[AW-1:0];
  end

  // Data memory: one write port shared with the clearing sweep, one read port.
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      dmem[clr_idx] <= 32'd0;
    end else if (x_fire && !halt_flag && (xu.op == OP_SW)) begin
      dmem[idx_reg] <= vb;
    end
    dmem_rdata <= dmem[idx_reg];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy  <= 1'b1;
      clr_idx   <= '0;
      gpr_vld   <= '0;
      pc        <= '0;
      halt_flag <= 1'b0;
      v0_copy   <= '0;
      a0_copy   <= '0;
      x_valid   <= 1'b0;
      mph       <= MEM_ADDR;
      o_valid   <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == AW'(DMEM_WORDS - 1)) begin
          clr_busy <= 1'b0;
        end
      end

      if (x_take) begin
        x_valid <= 1'b1;
      end else if (x_fire) begin
        x_valid <= 1'b0;
      end

      if (x_fire) begin
        mph <= MEM_ADDR;
      end else if (x_valid && is_mem && !halt_flag) begin
        case (mph)
          MEM_ADDR:   mph <= MEM_RECIP;
          MEM_RECIP:  mph <= MEM_QUOT;
          MEM_QUOT:   mph <= MEM_IDX;
          MEM_IDX:    mph <= MEM_ACCESS;
          MEM_ACCESS: mph <= (xu.op == OP_LW) ? MEM_DATA : MEM_ACCESS;
          default:    mph <= MEM_DATA;
        endcase
      end

      if (gpr_we) begin
        gpr_vld[xu.wr_idx] <= 1'b1;
        if (xu.wr_idx == GPR_V0) v0_copy <= wval;
        if (xu.wr_idx == GPR_A0) a0_copy <= wval;
      end

      if (x_fire && !halt_flag && (flt == FLT_NONE)) begin
        pc <= npc;
        if (set_halt) halt_flag <= 1'b1;
      end

      if (x_fire) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (x_fire) begin
      o_reg_write   <= 1'b0;
      o_reg_index   <= '0;
      o_reg_value   <= '0;
      o_print_valid <= 1'b0;
      o_print_value <= '0;
      o_halted      <= halt_flag;
      o_fault       <= FLT_NONE;
      if (halt_flag) begin
        o_next_pc <= pc;
      end else if (flt != FLT_NONE) begin
        o_next_pc <= pc;
        o_fault   <= flt;
      end else begin
        o_next_pc     <= npc;
        o_halted      <= set_halt;
        o_print_valid <= prt;
        o_print_value <= prt ? a0_copy : 32'd0;
        if (gpr_we) begin
          o_reg_write <= 1'b1;
          o_reg_index <= xu.wr_idx;
          o_reg_value <= wval;
        end
      end
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.next_pc     = o_next_pc;
  assign rsp.reg_write   = o_reg_write;
  assign rsp.reg_index   = o_reg_index;
  assign rsp.reg_value   = o_reg_value;
  assign rsp.print_valid = o_print_valid;
  assign rsp.print_value = $signed(o_print_value);
  assign rsp.halted      = o_halted;
  assign rsp.fault       = o_fault;

endmodule

// ===== hdl/mips_subset_execute_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_core
// Executes a stream of MIPS subset instructions, one result item per item.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one 32-bit instruction word per item; rsp returns exactly one
//   result item per instruction, in order: next pc, register write, print
//   request, halt state and fault code.
//   Decode accepts items into a two-entry issue queue, so decode and execute
//   stall independently. Register and branch instructions follow each other
//   back to back while rsp takes results; each item passes the queue slot,
//   the execute operand registers and the result register. Loads and stores
//   step through the address reduction pipeline (two multiplies and two
//   subtracts), then access memory; loads add the registered data read.
//   After reset the data memory is cleared one word per cycle, all DMEM_WORDS
//   words, with req.ready low; the register file clears at once.
//   When rsp is stalled the result register holds, execute holds, then the
//   queue fills and req.ready drops. After the exit syscall every further
//   item returns the held pc with halted set.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit_core #(
  parameter int unsigned DMEM_WORDS = mse_pkg::DMEM_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mse_in_if.sink    req,
  mse_out_if.source rsp
);
  import mse_pkg::*;

  logic clearing;
  logic q_full;
  logic q_not_empty;
  logic push;
  logic pop;
  uop_t push_uop;
  uop_t q_head;

  mse_front u_front (
    .req      (req),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_uop (push_uop)
  );

  mse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_uop  (push_uop),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mse_back #(
    .DMEM_WORDS (DMEM_WORDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .clearing    (clearing),
    .rsp         (rsp)
  );

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("item accepted during memory clearing");

  a_fault_has_no_effects: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.fault != FLT_NONE)) |-> (!rsp.reg_write && !rsp.print_valid))
    else $error("faulting item reports a side effect");

  a_no_write_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.reg_write) |-> ((rsp.reg_index == GPR_ZERO) && (rsp.reg_value == '0)))
    else $error("register fields set without a write");

  a_halted_is_quiet: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.halted) |-> (!rsp.reg_write && !rsp.print_valid
                                   && (rsp.fault == FLT_NONE)))
    else $error("halted item reports activity");
`endif

endmodule

// ===== dv/mips_subset_execute_unit_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_core_test
// Feeds the MIPS subset execute unit directed and random instruction streams.
// An architectural model of registers, pc and data memory predicts each result
// item, which is checked field by field as it arrives.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit_core_test;
  import mse_pkg::*;

  localparam int unsigned MEM_WORDS  = DMEM_WORDS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        print_valid;
    logic [31:0] print_value;
    logic        halted;
    logic [1:0]  fault;
  } arch_result_t;

  logic clk;
  logic rst;

  mse_in_if  req ();
  mse_out_if rsp ();

  mips_subset_execute_unit_core #(.DMEM_WORDS(MEM_WORDS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Architectural state seen by the predictor.
  logic [31:0] arch_gpr [32];
  logic [31:0] arch_mem [MEM_WORDS];
  logic [31:0] arch_pc;
  logic        arch_halt;

  logic [31:0]  instr_queue [$];
  arch_result_t expected_results [$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned print_count;
  int unsigned fault_count;
  int unsigned send_gap;
  int unsigned recv_gap;
  bit          idle_enable;
  bit          hold_sender;
  bit          stim_done;
  bit          last_accepted;

  function automatic logic [31:0] sign_ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic int unsigned word_index(input logic [31:0] addr);
    return (addr >> 2) % MEM_WORDS;
  endfunction

  function automatic arch_result_t execute_instr(input logic [31:0] ins);
    arch_result_t res;
    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd, sh, widx;
    logic [31:0] vs, vt, simm, seq, npc, wval;
    logic        wr;
    logic [1:0]  flt;
    logic        prt;
    res  = '0;
    opc  = ins[31:26];
    rs   = ins[25:21];
    rt   = ins[20:16];
    rd   = ins[15:11];
    sh   = ins[10:6];
    fn   = ins[5:0];
    simm = sign_ext16(ins[15:0]);
    vs   = arch_gpr[rs];
    vt   = arch_gpr[rt];
    seq  = arch_pc + 32'd4;
    npc  = seq;
    wr   = 1'b1;
    wval = '0;
    flt  = FLT_NONE;
    prt  = 1'b0;
    if (arch_halt) begin
      res.next_pc = arch_pc;
      res.halted  = 1'b1;
      return res;
    end
    if (opc == OPC_SPECIAL) begin
      widx = rd;
      case (fn)
        FN_SLL: wval = vt << sh;
        FN_SRL: wval = vt >> sh;
        FN_JR: begin
          wr = 1'b0;
          npc = vs;
        end
        FN_SYSCALL: begin
          wr = 1'b0;
          if (arch_gpr[GPR_V0] == SYS_PRINT_INT) begin
            prt = 1'b1;
            res.print_value = arch_gpr[GPR_A0];
          end else if (arch_gpr[GPR_V0] == SYS_EXIT) begin
            arch_halt = 1'b1;
          end else begin
            flt = FLT_SYSCALL;
          end
        end
        FN_ADD, FN_ADDU: wval = vs + vt;
        FN_SUB, FN_SUBU: wval = vs - vt;
        FN_AND: wval = vs & vt;
        FN_OR:  wval = vs | vt;
        FN_NOR: wval = ~(vs | vt);
        FN_SLT: wval = ($signed(vs) < $signed(vt)) ? 32'd1 : 32'd0;
        FN_SLTU: wval = (vs < vt) ? 32'd1 : 32'd0;
        default: begin
          wr = 1'b0;
          flt = FLT_FUNCT;
        end
      endcase
    end else begin
      widx = rt;
      case (opc)
        OPC_J: begin
          wr = 1'b0;
          npc = (seq & 32'hF000_0000) | {4'b0, ins[25:0], 2'b00};
        end
        OPC_JAL: begin
          widx = GPR_RA;
          wval = seq;
          npc = (seq & 32'hF000_0000) | {4'b0, ins[25:0], 2'b00};
        end
        OPC_BEQ: begin
          wr = 1'b0;
          if (vs == vt) npc = seq + (simm << 2);
        end
        OPC_BNE: begin
          wr = 1'b0;
          if (vs != vt) npc = seq + (simm << 2);
        end
        OPC_ADDI, OPC_ADDIU: wval = vs + simm;
        OPC_SLTI: wval = ($signed(vs) < $signed(simm)) ? 32'd1 : 32'd0;
        OPC_SLTIU: wval = (vs < simm) ? 32'd1 : 32'd0;
        OPC_ANDI: wval = vs & {16'b0, ins[15:0]};
        OPC_ORI:  wval = vs | {16'b0, ins[15:0]};
        OPC_LUI:  wval = {ins[15:0], 16'b0};
        OPC_LW:   wval = arch_mem[word_index(vs + simm)];
        OPC_SW: begin
          wr = 1'b0;
          arch_mem[word_index(vs + simm)] = vt;
        end
        default: begin
          wr = 1'b0;
          flt = FLT_OPCODE;
        end
      endcase
    end
    if (flt != FLT_NONE) begin
      res = '0;
      res.next_pc = arch_pc;
      res.fault = flt;
      return res;
    end
    if (wr && widx != GPR_ZERO) begin
      arch_gpr[widx] = wval;
    end else begin
      wr = 1'b0;
      widx = '0;
      wval = '0;
    end
    arch_pc = npc;
    res.next_pc     = npc;
    res.reg_write   = wr;
    res.reg_index   = widx;
    res.reg_value   = wval;
    res.print_valid = prt;
    res.halted      = arch_halt;
    return res;
  endfunction

  // Instruction builders.
  function automatic logic [31:0] r_op(input logic [5:0] fn, input logic [4:0] rs,
                                       input logic [4:0] rt, input logic [4:0] rd,
                                       input logic [4:0] sh);
    return {OPC_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_op(input logic [5:0] opc, input logic [4:0] rs,
                                       input logic [4:0] rt, input logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [4:0] rand_reg();
    // Favor a handful of registers so values are reused.
    if ($urandom_range(0, 3) != 0) return 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [15:0] rand_imm();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 64));
      3: return 16'h8000 | 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [5:0] fn_set [13];
    logic [5:0] op_set [13];
    logic [4:0] rs, rt, rd;
    logic [15:0] imm;
    fn_set = '{FN_SLL, FN_SRL, FN_JR, FN_SYSCALL, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
               FN_AND, FN_OR, FN_NOR, FN_SLT, FN_SLTU};
    op_set = '{OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE, OPC_ADDI, OPC_ADDIU, OPC_SLTI,
               OPC_SLTIU, OPC_ANDI, OPC_ORI, OPC_LUI, OPC_LW, OPC_SW};
    rs = rand_reg();
    rt = rand_reg();
    rd = rand_reg();
    imm = rand_imm();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: begin
        // Keep syscalls and jr rare so the stream is mostly straight-line.
        if ($urandom_range(0, 9) == 0)
          return r_op(fn_set[$urandom_range(2, 3)], rs, rt, rd, 5'($urandom));
        return r_op(fn_set[$urandom_range(4, 12)], rs, rt, rd, 5'($urandom));
      end
      7: return r_op(fn_set[$urandom_range(0, 1)], rs, rt, rd, 5'($urandom));
      8, 9, 10, 11, 12, 13, 14: return i_op(op_set[$urandom_range(4, 10)], rs, rt, imm);
      15, 16: return i_op(op_set[$urandom_range(11, 12)], rs, rt, imm);
      17: return i_op(op_set[$urandom_range(2, 3)], rs, rt, imm);
      18: begin
        if ($urandom_range(0, 1) == 0) return {op_set[$urandom_range(0, 1)], 26'($urandom)};
        return $urandom;
      end
      default: return {OPC_SPECIAL, 20'($urandom), 6'($urandom)};
    endcase
  endfunction

  task automatic wait_drained();
    while (expected_results.size() != 0 || instr_queue.size() != 0 || req.valid)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_count, expected_results.size());
        $display("mips_subset_execute_unit_core_test: errors");
        $finish;
      end
    end
  end

  // Driver: presents queued instructions, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.instr <= '0;
      send_gap  <= 0;
    end else if (req.valid && !last_accepted) begin
      // Hold the current item until it is taken.
    end else if (send_gap != 0) begin
      send_gap  <= send_gap - 1;
      req.valid <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      send_gap  <= $urandom_range(0, 2);
      req.valid <= 1'b0;
    end else if (!hold_sender && instr_queue.size() != 0) begin
      req.valid <= 1'b1;
      req.instr <= instr_queue.pop_front();
    end else begin
      req.valid <= 1'b0;
    end
  end

  // Predict at acceptance.
  always @(posedge clk) begin
    last_accepted = 1'b0;
    if (!rst && req.valid && req.ready) begin
      last_accepted = 1'b1;
      expected_results.push_back(execute_instr(req.instr));
      sent_count++;
    end
  end

  // Receiver stalls.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_gap  <= 0;
    end else if (recv_gap != 0) begin
      recv_gap  <= recv_gap - 1;
      rsp.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      recv_gap  <= $urandom_range(0, 2);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Monitor and checker.
  always @(posedge clk) begin
    arch_result_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.next_pc, rsp.reg_write, rsp.reg_index, rsp.reg_value,
              rsp.print_valid, rsp.print_value, rsp.halted, rsp.fault};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (want.print_valid) print_count++;
        if (want.fault != FLT_NONE) fault_count++;
        if (got.next_pc != want.next_pc || got.reg_write != want.reg_write ||
            got.reg_index != want.reg_index || got.reg_value != want.reg_value ||
            got.print_valid != want.print_valid || got.print_value != want.print_value ||
            got.halted != want.halted || got.fault != want.fault) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch on result %0d", checked_count);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  initial begin
    logic [31:0] directed [$];
    int unsigned n;
    for (int i = 0; i < 32; i++) arch_gpr[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) arch_mem[i] = '0;
    arch_pc        = '0;
    arch_halt      = 1'b0;
    mismatch_count = 0;
    sent_count     = 0;
    checked_count  = 0;
    print_count    = 0;
    fault_count    = 0;
    idle_enable    = 1'b1;
    hold_sender    = 1'b0;
    stim_done      = 1'b0;
    rst            = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation family and the named corner cases.
    directed = '{
      i_op(OPC_LUI, 5'd0, 5'd1, 16'h8000),
      i_op(OPC_ORI, 5'd1, 5'd1, 16'hFFFF),
      i_op(OPC_ADDI, 5'd0, 5'd3, 16'hFFFF),
      r_op(FN_ADD, 5'd1, 5'd3, 5'd5, 5'd0),
      r_op(FN_SUB, 5'd0, 5'd1, 5'd6, 5'd7),
      r_op(FN_SLT, 5'd1, 5'd3, 5'd7, 5'd0),
      r_op(FN_SLTU, 5'd1, 5'd3, 5'd8, 5'd0),
      r_op(FN_NOR, 5'd0, 5'd0, 5'd9, 5'd0),
      r_op(FN_SLL, 5'd31, 5'd3, 5'd10, 5'd31),
      r_op(FN_SRL, 5'd0, 5'd3, 5'd11, 5'd31),
      i_op(OPC_ADDIU, 5'd3, 5'd0, 16'h1234),
      i_op(OPC_SLTIU, 5'd0, 5'd12, 16'hFFFF),
      i_op(OPC_SLTI, 5'd3, 5'd13, 16'h0000),
      i_op(OPC_ANDI, 5'd3, 5'd14, 16'hFFFF),
      i_op(OPC_SW, 5'd3, 5'd1, 16'h7FFF),
      i_op(OPC_LW, 5'd3, 5'd15, 16'h7FFF),
      i_op(OPC_BEQ, 5'd0, 5'd0, 16'h8000),
      i_op(OPC_BNE, 5'd1, 5'd0, 16'h7FFF),
      {OPC_JAL, 26'h3FF_FFFF},
      {OPC_J, 26'h000_0000},
      r_op(FN_JR, 5'd1, 5'd0, 5'd0, 5'd0),
      {OPC_SPECIAL, 20'hFFFFF, 6'b111111},
      {6'b111111, 26'h3FF_FFFF},
      i_op(OPC_ADDI, 5'd0, 5'd2, 16'd1),
      r_op(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0)
    };
    foreach (directed[i]) instr_queue.push_back(directed[i]);
    instr_queue.push_back(r_op(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
    instr_queue.push_back(i_op(OPC_ADDI, 5'd0, 5'd2, 16'd7));
    instr_queue.push_back(r_op(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
    wait_drained();

    // Hold the sender until everything has been returned, then resume.
    hold_sender = 1'b1;
    instr_queue.push_back(i_op(OPC_ADDI, 5'd0, 5'd4, 16'h8001));
    while (expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    // Random body; v0 is kept away from the exit code until the end.
    n = 0;
    while (n < 1860) begin
      logic [31:0] ins;
      ins = rand_instr();
      if (ins[31:26] != OPC_SPECIAL && ins[31:26] != OPC_J && ins[31:26] != OPC_BEQ &&
          ins[31:26] != OPC_BNE && ins[31:26] != OPC_SW && ins[20:16] == GPR_V0)
        ins[20:16] = 5'd5;
      if (ins[31:26] == OPC_JAL) ins[31:26] = OPC_JAL;
      if (ins[31:26] == OPC_SPECIAL && ins[15:11] == GPR_V0) ins[15:11] = 5'd6;
      if ($urandom_range(0, 20) == 0) begin
        instr_queue.push_back(i_op(OPC_ADDI, 5'd0, GPR_V0, 16'd1));
        n++;
      end
      instr_queue.push_back(ins);
      n++;
      if (n == 1500) idle_enable = 1'b0;
      if (instr_queue.size() > 16) while (instr_queue.size() > 4) @(posedge clk);
    end

    // Exit and a few ignored items.
    instr_queue.push_back(i_op(OPC_ADDI, 5'd0, GPR_V0, 16'd10));
    instr_queue.push_back(r_op(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
    for (int i = 0; i < 8; i++) instr_queue.push_back(rand_instr());
    wait_drained();
    repeat (20) @(posedge clk);

    $display("executed %0d instructions and checked %0d results", sent_count, checked_count);
    $display("%0d print syscalls, %0d faults, halted %0d", print_count, fault_count, arch_halt);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("mips_subset_execute_unit_core_test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("mips_subset_execute_unit_core_test: errors");
    end
    $finish;
  end

endmodule
